// ----- sv/monotone_chain_convex_hull_macros.svh -----
// Assertion macros shared by the convex hull checker.
`ifndef MONOTONE_CHAIN_CONVEX_HULL_MACROS_SVH
`define MONOTONE_CHAIN_CONVEX_HULL_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MCH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MCH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- sv/mch_pkg.sv -----
// Package with types and constants of the convex hull block.
`timescale 1ns / 1ps
package mch_pkg;
  localparam int MaxPoints = 32;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = IdxW + 1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SORT_RD, ST_SORT_CMP, ST_DEDUP, ST_DEDUP_CMP,
    ST_CHAIN, ST_MUL1, ST_MUL2, ST_DECIDE, ST_EMIT_LO, ST_EMIT_UP, ST_SINGLE
  } state_t;

  // Lexicographic order key: biased x above biased y.
  function automatic logic [63:0] order_key(input logic [63:0] p);
    return p ^ 64'h8000_0000_8000_0000;
  endfunction
endpackage

// ----- sv/mch_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mch_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/monotone_chain_convex_hull.sv -----
// Top level of the monotone chain convex hull engine.
// Channel | Direction | Handshake          | Payload
// in_     | in        | start & !busy      | in_point_x, in_point_y, in_last_point
// out_    | out       | out_valid (strobe) | out_vertex_x/y, out_last_vertex,
//         |           |                    | out_points_dropped
// cfg_    | in        | cfg_valid & ready  | cfg_keep_collinear
// A point that is not last is stored while the store has room; busy stays low.
// The last point starts the hull: the insertion sort fetches each point, compares it
// with the points before it and places it, dedup drops repeated points, and each
// chain test runs through one shared 32x32 magnitude multiplier.
// Each result leaves once its index and point are read; the receiver cannot stall.
// Reset is synchronous and active low and clears control state only.
`timescale 1ns / 1ps
module monotone_chain_convex_hull
  import mch_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  input  logic        in_last_point,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_keep_collinear,
  output logic        out_valid,
  output logic [31:0] out_vertex_x,
  output logic [31:0] out_vertex_y,
  output logic        out_last_vertex,
  output logic        out_points_dropped
);
  // The point store is small enough to keep in flip-flops read at signal
  // addresses only through one port at a time; it still is a RAM instance.
  // Sorting runs through the RAM: read a[j-1], compare with the held key v,
  // shift it up or drop v in place.
  state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;       // points held
  logic            ovf_r, ovf_nxt;
  logic            keep_r;
  logic [CntW-1:0] i_r, i_nxt, j_r, j_nxt, m_r, m_nxt;
  logic [63:0]     v_r, v_nxt;           // held point
  logic [CntW-1:0] lo_r, lo_nxt, up_r, up_nxt;
  logic            side_r, side_nxt;     // 0 lower chain, 1 upper chain
  logic [2:0]      ph_r, ph_nxt;         // chain test phase
  logic [63:0]     pa_r, pa_nxt, pb_r, pb_nxt;
  logic [32:0]     dx1_r, dy1_r, dx2_r, dy2_r;
  logic [32:0]     dx1_nxt, dy1_nxt, dx2_nxt, dy2_nxt;
  logic [64:0]     m1_r, m1_nxt;
  logic            s1neg_r, s1neg_nxt;

  // RAM ports
  logic            pw_we;  logic [IdxW-1:0] pw_a, pr_a; logic [63:0] pw_d, pr_d;
  logic            lw_we;  logic [IdxW-1:0] lw_a, lr_a; logic [IdxW-1:0] lw_d, lr_d;
  logic            uw_we;  logic [IdxW-1:0] uw_a, ur_a; logic [IdxW-1:0] uw_d, ur_d;

  mch_ram #(.Width(64), .Depth(MaxPoints)) u_pts (
    .clk(clk), .we(pw_we), .waddr(pw_a), .wdata(pw_d), .raddr(pr_a), .rdata(pr_d));
  mch_ram #(.Width(IdxW), .Depth(MaxPoints)) u_lo (
    .clk(clk), .we(lw_we), .waddr(lw_a), .wdata(lw_d), .raddr(lr_a), .rdata(lr_d));
  mch_ram #(.Width(IdxW), .Depth(MaxPoints)) u_up (
    .clk(clk), .we(uw_we), .waddr(uw_a), .wdata(uw_d), .raddr(ur_a), .rdata(ur_d));

  // Shared multiplier: magnitude product of two 33-bit signed differences.
  logic [32:0] mul_a, mul_b;
  logic [31:0] mag_a, mag_b;
  logic [63:0] mul_p;
  assign mag_a = mul_a[32] ? 32'((~mul_a) + 33'd1) : mul_a[31:0];
  assign mag_b = mul_b[32] ? 32'((~mul_b) + 33'd1) : mul_b[31:0];
  assign mul_p = mag_a * mag_b;
  logic mul_neg;
  assign mul_neg = (mul_a[32] ^ mul_b[32]) && (mul_p != 64'd0);

  assign busy = (state_r != ST_LOAD);
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      keep_r <= cfg_keep_collinear;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; m_r <= m_nxt; v_r <= v_nxt;
    lo_r <= lo_nxt; up_r <= up_nxt; side_r <= side_nxt; ph_r <= ph_nxt;
    pa_r <= pa_nxt; pb_r <= pb_nxt; m1_r <= m1_nxt; s1neg_r <= s1neg_nxt;
    dx1_r <= dx1_nxt; dy1_r <= dy1_nxt; dx2_r <= dx2_nxt; dy2_r <= dy2_nxt;
  end

  function automatic logic [32:0] sdiff(input logic [31:0] a, input logic [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  logic [CntW-1:0] top;
  logic            pop;
  logic signed [1:0] tsign;
  logic [64:0]     m2;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; ovf_nxt = ovf_r;
    i_nxt = i_r; j_nxt = j_r; m_nxt = m_r; v_nxt = v_r;
    lo_nxt = lo_r; up_nxt = up_r; side_nxt = side_r; ph_nxt = ph_r;
    pa_nxt = pa_r; pb_nxt = pb_r; m1_nxt = m1_r; s1neg_nxt = s1neg_r;
    dx1_nxt = dx1_r; dy1_nxt = dy1_r; dx2_nxt = dx2_r; dy2_nxt = dy2_r;
    pw_we = 1'b0; pw_a = '0; pw_d = v_r; pr_a = '0;
    lw_we = 1'b0; lw_a = '0; lw_d = '0; lr_a = '0;
    uw_we = 1'b0; uw_a = '0; uw_d = '0; ur_a = '0;
    mul_a = dx1_r; mul_b = dy2_r;
    out_valid = 1'b0; out_vertex_x = pr_d[63:32]; out_vertex_y = pr_d[31:0];
    out_last_vertex = 1'b0; out_points_dropped = ovf_r;
    top = side_r ? up_r : lo_r;
    m2 = {1'b0, mul_p};
    tsign = '0; pop = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (start) begin
          if (cnt_r < CntW'(MaxPoints)) begin
            pw_we = 1'b1; pw_a = cnt_r[IdxW-1:0];
            pw_d = {in_point_x, in_point_y};
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_point) begin
            i_nxt = CntW'(1);
            ph_nxt = 3'd0;
            state_nxt = ST_SORT_RD;
          end
        end
      end
      ST_SORT_RD: begin
        // Fetch v = a[i]; j = i.
        if (i_r >= cnt_r) begin
          i_nxt = '0; m_nxt = '0;
          state_nxt = ST_DEDUP;
        end else if (ph_r == 3'd0) begin
          pr_a = i_r[IdxW-1:0]; ph_nxt = 3'd1;
        end else begin
          v_nxt = pr_d; j_nxt = i_r; ph_nxt = 3'd0;
          pr_a = IdxW'(i_r - 1'b1);
          state_nxt = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        // pr_d holds a[j-1].
        if (order_key(pr_d) > order_key(v_r)) begin
          pw_we = 1'b1; pw_a = j_r[IdxW-1:0]; pw_d = pr_d;
          j_nxt = j_r - 1'b1;
          if (j_r == CntW'(1)) begin
            pw_we = 1'b1;
            // write shift now; v goes to index 0 in the placement cycle
            ph_nxt = 3'd2;
          end
          pr_a = IdxW'(j_r - 2'd2);
          if (j_r == CntW'(1)) begin
            state_nxt = ST_SORT_CMP;
          end
        end else begin
          ph_nxt = 3'd3;
        end
        if (ph_r == 3'd2 || ph_r == 3'd3) begin
          pw_we = 1'b1; pw_a = j_r[IdxW-1:0]; pw_d = v_r;
          ph_nxt = 3'd0; i_nxt = i_r + 1'b1; j_nxt = j_r;
          state_nxt = ST_SORT_RD;
        end
      end
      ST_DEDUP: begin
        // Read a[i], compare with last kept point held in v.
        if (i_r >= cnt_r) begin
          cnt_nxt = m_r; i_nxt = '0; lo_nxt = '0; up_nxt = '0;
          side_nxt = 1'b0; ph_nxt = 3'd0;
          state_nxt = (m_r <= CntW'(1)) ? ST_SINGLE : ST_CHAIN;
        end else begin
          pr_a = i_r[IdxW-1:0];
          state_nxt = ST_DEDUP_CMP;
        end
      end
      ST_DEDUP_CMP: begin
        if (m_r == '0 || pr_d != v_r) begin
          pw_we = 1'b1; pw_a = m_r[IdxW-1:0]; pw_d = pr_d;
          v_nxt = pr_d; m_nxt = m_r + 1'b1;
        end
        i_nxt = i_r + 1'b1;
        state_nxt = ST_DEDUP;
      end
      ST_CHAIN: begin
        // Phase 0: read stack[top-2], 1: stack[top-1] idx; 2..4 fetch points.
        if (i_r >= cnt_r && !side_r) begin
          i_nxt = '0; ph_nxt = 3'd0;
          state_nxt = ST_EMIT_LO;
        end else if (top < CntW'(2)) begin
          pop = 1'b0;
          if (side_r) begin
            uw_we = 1'b1; uw_a = up_r[IdxW-1:0]; uw_d = i_r[IdxW-1:0];
            up_nxt = up_r + 1'b1; side_nxt = 1'b0; i_nxt = i_r + 1'b1;
          end else begin
            lw_we = 1'b1; lw_a = lo_r[IdxW-1:0]; lw_d = i_r[IdxW-1:0];
            lo_nxt = lo_r + 1'b1; side_nxt = 1'b1;
          end
          ph_nxt = 3'd0;
        end else begin
          unique case (ph_r)
            3'd0: begin
              lr_a = IdxW'(top - 2'd2); ur_a = IdxW'(top - 2'd2); ph_nxt = 3'd1;
            end
            3'd1: begin
              pr_a = side_r ? ur_d : lr_d;
              lr_a = IdxW'(top - 1'b1); ur_a = IdxW'(top - 1'b1); ph_nxt = 3'd2;
            end
            3'd2: begin
              pa_nxt = pr_d; pr_a = side_r ? ur_d : lr_d; ph_nxt = 3'd3;
            end
            3'd3: begin
              pb_nxt = pr_d; pr_a = i_r[IdxW-1:0]; ph_nxt = 3'd4;
            end
            default: begin
              dx1_nxt = sdiff(pb_r[63:32], pa_r[63:32]);
              dy1_nxt = sdiff(pb_r[31:0], pa_r[31:0]);
              dx2_nxt = sdiff(pr_d[63:32], pa_r[63:32]);
              dy2_nxt = sdiff(pr_d[31:0], pa_r[31:0]);
              ph_nxt = 3'd0;
              state_nxt = ST_MUL1;
            end
          endcase
        end
      end
      ST_MUL1: begin
        mul_a = dx1_r; mul_b = dy2_r;
        m1_nxt = {1'b0, mul_p}; s1neg_nxt = mul_neg;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        mul_a = dy1_r; mul_b = dx2_r;
        // Signed compare of m1 and m2 via sign-magnitude.
        if (s1neg_r != mul_neg) begin
          tsign = s1neg_r ? -2'sd1 : 2'sd1;
          if (m1_r == '0 && mul_p == '0) tsign = 2'sd0;
        end else if (m1_r == m2) begin
          tsign = 2'sd0;
        end else if (!s1neg_r) begin
          tsign = (m1_r > m2) ? 2'sd1 : -2'sd1;
        end else begin
          tsign = (m1_r > m2) ? -2'sd1 : 2'sd1;
        end
        if (side_r) pop = keep_r ? (tsign == 2'sd1) : (tsign >= 2'sd0);
        else        pop = keep_r ? (tsign == -2'sd1) : (tsign <= 2'sd0);
        if (pop) begin
          if (side_r) up_nxt = up_r - 1'b1; else lo_nxt = lo_r - 1'b1;
          state_nxt = ST_CHAIN;
        end else begin
          if (side_r) begin
            uw_we = 1'b1; uw_a = up_r[IdxW-1:0]; uw_d = i_r[IdxW-1:0];
            up_nxt = up_r + 1'b1; side_nxt = 1'b0; i_nxt = i_r + 1'b1;
          end else begin
            lw_we = 1'b1; lw_a = lo_r[IdxW-1:0]; lw_d = i_r[IdxW-1:0];
            lo_nxt = lo_r + 1'b1; side_nxt = 1'b1;
          end
          state_nxt = ST_CHAIN;
        end
      end
      ST_EMIT_LO: begin
        // Pipeline: ph 0 read chain index, 1 read point, 2 emit.
        unique case (ph_r)
          3'd0: begin
            if (i_r + 1'b1 >= lo_r) begin
              i_nxt = up_r; state_nxt = ST_EMIT_UP;
            end else begin
              lr_a = i_r[IdxW-1:0]; ph_nxt = 3'd1;
            end
          end
          3'd1: begin
            pr_a = lr_d; ph_nxt = 3'd2;
          end
          default: begin
            out_valid = 1'b1;
            i_nxt = i_r + 1'b1; ph_nxt = 3'd0;
          end
        endcase
      end
      ST_EMIT_UP: begin
        unique case (ph_r)
          3'd0: begin
            ur_a = IdxW'(i_r - 1'b1); ph_nxt = 3'd1;
          end
          3'd1: begin
            pr_a = ur_d; ph_nxt = 3'd2;
          end
          default: begin
            out_valid = 1'b1;
            out_last_vertex = (i_r == CntW'(2));
            i_nxt = i_r - 1'b1; ph_nxt = 3'd0;
            if (i_r == CntW'(2)) begin
              cnt_nxt = '0; ovf_nxt = 1'b0; state_nxt = ST_LOAD;
            end
          end
        endcase
      end
      ST_SINGLE: begin
        if (ph_r == 3'd0) begin
          pr_a = '0; ph_nxt = 3'd1;
        end else begin
          out_valid = 1'b1; out_last_vertex = 1'b1; ph_nxt = 3'd0;
          cnt_nxt = '0; ovf_nxt = 1'b0; state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end
endmodule

// ----- sv/mch_checker.sv -----
// Port-level checker for the convex hull block and its bind.
`timescale 1ns / 1ps
`include "monotone_chain_convex_hull_macros.svh"
module mch_checker
  import mch_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_point,
  input logic cfg_ready,
  input logic out_valid,
  input logic out_last_vertex
);
  // No result leaves while the block is idle.
  `MCH_ASSERT_IMP(a_out_busy, clk, rst_n, out_valid, busy)
  // A closing point always makes the block busy.
  `MCH_ASSERT_NXT(a_last_busy, clk, rst_n, start && !busy && in_last_point, busy)
  // The final vertex ends the hull.
  `MCH_ASSERT_NXT(a_last_idle, clk, rst_n, out_valid && out_last_vertex, !busy)
  // Configuration is taken only while idle.
  `MCH_ASSERT_IMP(a_cfg_idle, clk, rst_n, cfg_ready, !busy)
endmodule

bind monotone_chain_convex_hull mch_checker u_mch_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_last_point(in_last_point), .cfg_ready(cfg_ready),
  .out_valid(out_valid), .out_last_vertex(out_last_vertex));
